// ----- design/grl_pkg.sv -----
// shared constants and controller/datapath command and status types
// for the geometric level draw block; no dependencies
package grl_pkg;

    // field widths
    localparam int GRL_M_W   = 10;
    localparam int GRL_LVL_W = 5;
    localparam int GRL_ST_W  = 31;
    localparam int GRL_S_W   = 21;
    localparam int GRL_B_W   = GRL_M_W + 1;
    localparam int GRL_T_W   = GRL_S_W + GRL_B_W;

    // default saturation level
    localparam int GRL_MAX_LEVEL = 31;

    // lehmer generator constants
    localparam logic [15:0]         GRL_LEHMER_MUL = 16'd48271;
    localparam logic [GRL_ST_W-1:0] GRL_LEHMER_MOD = 31'h7FFF_FFFF;

    // sample scaling: divisor is 2^11 - 1
    localparam int                  GRL_DIV_SH   = 11;
    localparam logic [GRL_T_W-1:0]  GRL_RANGE    = 32'd1049088;
    localparam int                  GRL_DIV_STEPS = 4;

    // controller to datapath commands
    typedef struct packed {
        logic load;
        logic gen_mul;
        logic gen_fold;
        logic prep;
        logic div_step;
        logic div_fix;
        logic srch_step;
        logic out_load;
    } grl_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic search_end;
        logic out_busy;
    } grl_status_t;

endpackage

// ----- design/grl_ctrl.sv -----
// sequencer for the level draw: steps the datapath through generator,
// sample scaling and level search; uses grl_pkg
module grl_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic                 out_stall,
    input  grl_pkg::grl_status_t status,
    output grl_pkg::grl_cmd_t    cmd
);
    import grl_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL  = 3'd1;
    localparam logic [2:0] ST_FOLD = 3'd2;
    localparam logic [2:0] ST_PREP = 3'd3;
    localparam logic [2:0] ST_DIV  = 3'd4;
    localparam logic [2:0] ST_CORR = 3'd5;
    localparam logic [2:0] ST_SRCH = 3'd6;
    localparam logic [2:0] ST_DONE = 3'd7;

    localparam int CNT_W = $clog2(GRL_DIV_STEPS);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(GRL_DIV_STEPS - 1);

    logic [2:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                cmd.gen_mul = 1'b1;
                state_next  = ST_FOLD;
            end
            ST_FOLD:
            begin
                cmd.gen_fold = 1'b1;
                state_next   = ST_PREP;
            end
            ST_PREP:
            begin
                cmd.prep   = 1'b1;
                cnt_next   = '0;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST)
                begin
                    state_next = ST_CORR;
                end
            end
            ST_CORR:
            begin
                cmd.div_fix = 1'b1;
                state_next  = ST_SRCH;
            end
            ST_SRCH:
            begin
                cmd.srch_step = 1'b1;
                if (status.search_end)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                // hand over once the output register is free or draining
                if (!status.out_busy || !out_stall)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

// ----- design/grl_dp.sv -----
// datapath for the level draw: lehmer generator, divide by 2047 through
// digit folding, level search multiplier and output register; uses grl_pkg
module grl_dp #(
    parameter int MAX_LEVEL = grl_pkg::GRL_MAX_LEVEL
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  grl_pkg::grl_cmd_t             cmd,
    output grl_pkg::grl_status_t          status,
    input  logic [grl_pkg::GRL_M_W-1:0]   links_per_node,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [grl_pkg::GRL_LVL_W-1:0] level,
    output logic                          sample_was_zero
);
    import grl_pkg::*;

    localparam int KW = $clog2(MAX_LEVEL + 1);
    localparam logic [KW-1:0] K_MAX = KW'(MAX_LEVEL);
    localparam int PROD_W = GRL_ST_W + 16;

    logic [GRL_B_W-1:0]   base_reg;
    logic                 m_zero_reg;
    logic [GRL_ST_W-1:0]  gen_reg, gen_next;
    logic [PROD_W-1:0]    gprod_reg;
    logic [GRL_ST_W-1:0]  x_reg;
    logic [GRL_S_W-1:0]   q_reg;
    logic [GRL_S_W-1:0]   prod_reg;
    logic                 zero_reg;
    logic [KW-1:0]        k_reg;
    logic                 out_valid_reg;
    logic [GRL_LVL_W-1:0] level_reg;
    logic                 zero_out_reg;

    // generator: fold the product modulo 2^31 - 1
    logic [GRL_ST_W:0] fold_sum;
    always_comb
    begin
        fold_sum = {1'b0, gprod_reg[GRL_ST_W-1:0]}
                 + {{(GRL_ST_W + 1 - 16){1'b0}}, gprod_reg[PROD_W-1:GRL_ST_W]};
        if (fold_sum >= {1'b0, GRL_LEHMER_MOD})
        begin
            gen_next = GRL_ST_W'(fold_sum - {1'b0, GRL_LEHMER_MOD});
        end
        else
        begin
            gen_next = fold_sum[GRL_ST_W-1:0];
        end
    end

    // divide by 2047: x = a*2048 + b gives q += a, x = a + b
    logic [GRL_ST_W-GRL_DIV_SH-1:0] div_hi;
    logic [GRL_DIV_SH-1:0]          div_lo;
    logic [GRL_ST_W-1:0]            x_step;
    logic [GRL_S_W-1:0]             q_step;
    logic [GRL_S_W-1:0]             s_val;
    always_comb
    begin
        div_hi = x_reg[GRL_ST_W-1:GRL_DIV_SH];
        div_lo = x_reg[GRL_DIV_SH-1:0];
        x_step = {{GRL_DIV_SH{1'b0}}, div_hi}
               + {{(GRL_ST_W - GRL_DIV_SH){1'b0}}, div_lo};
        q_step = q_reg + {{(GRL_S_W - (GRL_ST_W - GRL_DIV_SH)){1'b0}}, div_hi};
        // remainder of exactly the divisor adds one more
        s_val  = q_reg + {{(GRL_S_W - 1){1'b0}},
                          (x_reg == {{(GRL_ST_W - GRL_DIV_SH){1'b0}}, {GRL_DIV_SH{1'b1}}})};
    end

    // level search: one multiply by the base per step
    logic [GRL_T_W-1:0] trial;
    logic               trial_over;
    logic               direct_max;
    assign trial      = {{GRL_B_W{1'b0}}, prod_reg} * {{GRL_S_W{1'b0}}, base_reg};
    assign trial_over = (trial > GRL_RANGE);
    assign direct_max = zero_reg || m_zero_reg;

    assign status.search_end = direct_max || (k_reg == K_MAX) || trial_over;
    assign status.out_busy   = out_valid_reg;

    // generator state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gen_reg <= {{(GRL_ST_W - 1){1'b0}}, 1'b1};
        end
        else if (cmd.gen_fold)
        begin
            gen_reg <= gen_next;
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            base_reg   <= {1'b0, links_per_node} + 1'b1;
            m_zero_reg <= (links_per_node == '0);
        end
        if (cmd.gen_mul)
        begin
            gprod_reg <= {16'd0, gen_reg} * {{GRL_ST_W{1'b0}}, GRL_LEHMER_MUL};
        end
        if (cmd.prep)
        begin
            x_reg <= gen_reg - 1'b1;
            q_reg <= '0;
        end
        if (cmd.div_step)
        begin
            x_reg <= x_step;
            q_reg <= q_step;
        end
        if (cmd.div_fix)
        begin
            prod_reg <= s_val;
            zero_reg <= (s_val == '0);
            k_reg    <= '0;
        end
        if (cmd.srch_step)
        begin
            if (direct_max)
            begin
                k_reg <= K_MAX;
            end
            else if (!status.search_end)
            begin
                prod_reg <= trial[GRL_S_W-1:0];
                k_reg    <= k_reg + 1'b1;
            end
        end
        if (cmd.out_load)
        begin
            level_reg    <= k_reg[GRL_LVL_W-1:0];
            zero_out_reg <= zero_reg;
        end
    end

    // output word valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid       = out_valid_reg;
    assign level           = level_reg;
    assign sample_was_zero = zero_out_reg;

endmodule

// ----- design/graph_index_random_level_top.sv -----
// timing: the level search loop sets how long a word takes from accept to
// result valid, one multiply by M+1 per cycle, at most 21 steps
// flow: one word at a time; a new word is taken once the previous one has
// moved into the output register, which holds it until taken
// reset: asynchronous active low; generator state returns to one, no word held
module graph_index_random_level_top #(
    parameter int MAX_LEVEL = grl_pkg::GRL_MAX_LEVEL
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [grl_pkg::GRL_M_W-1:0]   links_per_node,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [grl_pkg::GRL_LVL_W-1:0] level,
    output logic                          sample_was_zero
);
    import grl_pkg::*;

    grl_cmd_t    cmd;
    grl_status_t status;

    // sequencer
    grl_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    // datapath
    grl_dp #(
        .MAX_LEVEL (MAX_LEVEL)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .links_per_node  (links_per_node),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .level           (level),
        .sample_was_zero (sample_was_zero)
    );

endmodule

// ----- design/grl_checker.sv -----
// port level checks for the level draw block, bound to the top level;
// uses grl_pkg for field widths
module grl_checker #(
    parameter int MAX_LEVEL = grl_pkg::GRL_MAX_LEVEL
) (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_stall,
    input logic [grl_pkg::GRL_M_W-1:0]   links_per_node,
    input logic                          out_valid,
    input logic                          out_stall,
    input logic [grl_pkg::GRL_LVL_W-1:0] level,
    input logic                          sample_was_zero
);
    import grl_pkg::*;

    localparam logic [GRL_LVL_W-1:0] LVL_SAT = GRL_LVL_W'(MAX_LEVEL);

    // a stalled input word holds
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid && $stable(links_per_node))
        else $error("stalled input word changed");

    // a stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(level) && $stable(sample_was_zero))
        else $error("stalled result word changed");

    // one word in flight: input stalls right after an accept
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input taken while a word is in flight");

    // the draw pipeline cannot finish sooner than its fixed steps
    a_min_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |-> ##9 in_stall)
        else $error("word finished too early");

    // a zero sample saturates the level
    a_zero_sat: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && sample_was_zero |-> level == LVL_SAT)
        else $error("zero sample without saturated level");

endmodule

bind graph_index_random_level_top grl_checker #(.MAX_LEVEL(MAX_LEVEL)) u_grl_checker (.*);
